// ===== design/vtx_pkg.sv =====
// Shared types, constants and helpers for the 4x4 vertex transform.
`timescale 1ns / 1ps
`default_nettype none

package vtx_pkg;

   localparam int DATA_W = 32;                       // Q16.16 word
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W;               // Q32.32 product
   localparam int ACC_W  = PROD_W + 2;               // four products, exact
   localparam int IDX_W  = 4;                        // 16 matrix entries
   localparam int SEL_W  = 2;                        // row or column

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_XFORM = 1'b1;

   localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   // control word that rides along with each product through the datapath
   typedef struct packed {
      logic             valid;
      logic             first;   // column 0: restart the row sum
      logic             last;    // column 3: row sum complete
      logic [SEL_W-1:0] row;
   } ctl_type;

   // one finished output component
   typedef struct packed {
      logic                     valid;
      logic [SEL_W-1:0]         row;
      logic signed [DATA_W-1:0] value;
      logic                     sat;
   } res_type;

   function automatic logic signed [DATA_W-1:0] identity_entry(logic [IDX_W-1:0] idx);
      return (idx[3:2] == idx[1:0]) ? Q_ONE : '0;
   endfunction

endpackage

`default_nettype wire

// ===== design/vtx_matrix.sv =====
// Matrix entry store with identity reset, one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vtx_matrix (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             wr_en,
   input  wire logic [vtx_pkg::IDX_W-1:0]        wr_addr,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] wr_data,
   input  wire logic [vtx_pkg::IDX_W-1:0]        rd_addr,
   output logic signed [vtx_pkg::DATA_W-1:0]     rd_data_ff
);

   localparam int DEPTH = 1 << vtx_pkg::IDX_W;

   logic signed [vtx_pkg::DATA_W-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            store_ff[i] <= vtx_pkg::identity_entry(vtx_pkg::IDX_W'(i));
         end
      end else if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/vtx_mac.sv =====
// Shared multiply-accumulate unit: one product per cycle, row sum, floor and saturate.
`timescale 1ns / 1ps
`default_nettype none

module vtx_mac (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire vtx_pkg::ctl_type                  ctl,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] op_a,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] op_b,
   output vtx_pkg::res_type                       res
);

   localparam int SH_W = vtx_pkg::ACC_W - vtx_pkg::FRAC_W;

   vtx_pkg::ctl_type                   ctl_prod_ff;
   vtx_pkg::ctl_type                   ctl_acc_ff;
   logic signed [vtx_pkg::PROD_W-1:0]  prod_ff;
   logic signed [vtx_pkg::ACC_W-1:0]   acc_ff;
   logic signed [vtx_pkg::ACC_W-1:0]   acc_base;
   logic signed [vtx_pkg::ACC_W-1:0]   acc_in;
   logic signed [SH_W-1:0]             shifted;
   logic [SH_W-vtx_pkg::DATA_W:0]      top_bits;
   logic                               in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_prod_ff <= '0;
         ctl_acc_ff  <= '0;
      end else begin
         ctl_prod_ff <= ctl;
         ctl_acc_ff  <= ctl_prod_ff;
      end
   end

   always_comb begin
      acc_base = ctl_prod_ff.first ? '0 : acc_ff;
      acc_in   = acc_base + vtx_pkg::ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (ctl_prod_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // dropping the low fraction bits of the exact sum rounds toward minus infinity
   always_comb begin
      shifted   = acc_ff[vtx_pkg::ACC_W-1:vtx_pkg::FRAC_W];
      top_bits  = shifted[SH_W-1:vtx_pkg::DATA_W-1];
      in_range  = (&top_bits) || (~|top_bits);
      res.valid = ctl_acc_ff.valid && ctl_acc_ff.last;
      res.row   = ctl_acc_ff.row;
      res.sat   = !in_range;
      priority if (in_range) begin
         res.value = shifted[vtx_pkg::DATA_W-1:0];
      end else if (shifted[SH_W-1]) begin
         res.value = vtx_pkg::SAT_MIN;
      end else begin
         res.value = vtx_pkg::SAT_MAX;
      end
   end

endmodule

`default_nettype wire

// ===== design/vertex_transform_mat4_vec4.sv =====
// Top level: 4x4 Q16.16 matrix times vector transform with sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

// A load beat (kind 0) writes one matrix entry and gives no result. A
// transform beat (kind 1) runs the 16 matrix entries one per cycle through a
// single 32x32 multiplier and a 66-bit accumulator; the result beat shows up
// once the last row sum is done, and a new request is taken in that same cycle
// if the result is consumed at once. No new transform is taken while one runs,
// as the one multiplier is shared. Each component
// is the exact row sum floored to Q16.16 and clipped to 32 bits; rsp_saturated
// flags any clip. The matrix resets to identity. While a result waits, load
// beats are still taken.
module vertex_transform_mat4_vec4 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [1:0]                        req_row,
   input  wire logic [1:0]                        req_col,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] req_entry_value,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] req_vec_x,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] req_vec_y,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] req_vec_z,
   input  wire logic signed [vtx_pkg::DATA_W-1:0] req_vec_w,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [vtx_pkg::DATA_W-1:0]      rsp_out_x,
   output logic signed [vtx_pkg::DATA_W-1:0]      rsp_out_y,
   output logic signed [vtx_pkg::DATA_W-1:0]      rsp_out_z,
   output logic signed [vtx_pkg::DATA_W-1:0]      rsp_out_w,
   output logic                                   rsp_saturated
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam logic [vtx_pkg::IDX_W-1:0] IDX_LAST = '1;
   localparam logic [vtx_pkg::SEL_W-1:0] COL_LAST = '1;
   localparam logic [vtx_pkg::SEL_W-1:0] ROW_LAST = '1;

   logic [1:0]                        state_ff, state_in;
   logic [vtx_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic signed [vtx_pkg::DATA_W-1:0] vec_ff [4];
   logic signed [vtx_pkg::DATA_W-1:0] vec_b_ff;
   vtx_pkg::ctl_type                  ctl_rd_ff, ctl_rd_in;
   logic signed [vtx_pkg::DATA_W-1:0] mat_rd;
   vtx_pkg::res_type                  res;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [vtx_pkg::DATA_W-1:0] out_x_ff, out_y_ff, out_z_ff, out_w_ff;
   logic                              sat_ff;
   logic                              accept;
   logic                              load_en;
   logic                              xform_start;

   assign req_ready   = (state_ff == ST_IDLE)
                     && (req_kind == vtx_pkg::KIND_LOAD || !rsp_valid_ff || rsp_ready);
   assign accept      = req_valid && req_ready;
   assign load_en     = accept && (req_kind == vtx_pkg::KIND_LOAD);
   assign xform_start = accept && (req_kind == vtx_pkg::KIND_XFORM);

   // sequencer: walk the 16 entries in row-major order
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (xform_start) begin
               state_in = ST_ISSUE;
               idx_in   = '0;
            end
         end
         ST_ISSUE: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (res.valid && res.row == ROW_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl_rd_in.valid = (state_ff == ST_ISSUE);
      ctl_rd_in.first = (idx_ff[1:0] == '0);
      ctl_rd_in.last  = (idx_ff[1:0] == COL_LAST);
      ctl_rd_in.row   = idx_ff[3:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         ctl_rd_ff <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         ctl_rd_ff <= ctl_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xform_start) begin
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
         vec_ff[3] <= req_vec_w;
      end
      vec_b_ff <= vec_ff[idx_ff[1:0]];
   end

   vtx_matrix u_matrix (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (load_en),
      .wr_addr    ({req_row, req_col}),
      .wr_data    (req_entry_value),
      .rd_addr    (idx_ff),
      .rd_data_ff (mat_rd)
   );

   vtx_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl_rd_ff),
      .op_a  (mat_rd),
      .op_b  (vec_b_ff),
      .res   (res)
   );

   // output register collects the four row results
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid && res.row == ROW_LAST) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         unique case (res.row)
            2'd0: out_x_ff <= res.value;
            2'd1: out_y_ff <= res.value;
            2'd2: out_z_ff <= res.value;
            2'd3: out_w_ff <= res.value;
            default: out_x_ff <= res.value;
         endcase
         sat_ff <= (res.row == '0) ? res.sat : (sat_ff | res.sat);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_z     = out_z_ff;
   assign rsp_out_w     = out_w_ff;
   assign rsp_saturated = sat_ff;

endmodule

`default_nettype wire

// ===== design/vtx_checker.sv =====
// Port-level checks for the vertex transform, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module vtx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_kind,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_out_x,
   input wire logic        rsp_saturated
);

   // a stalled result beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled result beat keeps its x component and saturation flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_x) && $stable(rsp_saturated))
      else $error("result payload changed while stalled");

   // a transform occupies the unit and clears the output slot
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind |=> !req_ready && !rsp_valid)
      else $error("busy or stale result after transform start");

   // a load with nothing pending never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind && !rsp_valid |=> !rsp_valid)
      else $error("result beat after a load");

endmodule

bind vertex_transform_mat4_vec4 vtx_checker u_vtx_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_x     (rsp_out_x),
   .rsp_saturated (rsp_saturated)
);

`default_nettype wire
